>>> rtl/conv3_pkg.sv
// Shared types, constants and helpers for the 3x3 convolution filter.
package conv3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned COEF_BITS  = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned KREG_W     = 48;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIX_W      = 8;

  // Arithmetic widths: coef times unsigned pixel, then sums of three and nine
  localparam int unsigned PROD_W = COEF_BITS + PIX_W + 1;
  localparam int unsigned ROW_W  = PROD_W + 2;
  localparam int unsigned SUM_W  = PROD_W + 4;

  // Middle kernel row after reset: 1.0 at the centre tap
  localparam logic [KREG_W-1:0] KERN_MID_RESET = 48'h0000_0100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERN_TOP = 3'd0,
    CFG_KERN_MID = 3'd1,
    CFG_KERN_BOT = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Window indexed [row][col], row 0 on top, col 0 on the left
  typedef pix_t [2:0][2:0] win_t;

  typedef logic [2:0][KREG_W-1:0] kern_t;

  typedef struct packed {
    logic func;
    pix_t pixel_in;
  } in_req_t;

  typedef struct packed {
    pix_t pixel_out;
    logic run_last;
    logic frame_last;
  } out_rsp_t;

  // One filter evaluation handed from the window stage to the arithmetic
  typedef struct packed {
    win_t win;
    logic run_last;
    logic frame_last;
  } job_t;

  // Map zero to one and saturate at the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/conv3x3_zero_pad_clamp.sv
// Streaming 3x3 convolution with zero padding and 0..255 clamp (top level).
// A result is registered through the window, product, row-sum and output stages and
//   trails the input by one row and one pixel; at a row end a second result follows.
// Throughput: one pixel per clock while the output is not stalled; a row-end request
//   below the first row holds the window stage for an extra right-padding tail pass.
// The line buffer is one 1024 x 16 RAM, read at accept, written back on commit,
//   with a one-entry forward for back-to-back hits on one column.
// Reset clears counters, window, valid bits, presets config; line RAM is not cleared.
module conv3x3_zero_pad_clamp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [conv3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [conv3_pkg::KREG_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  conv3_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output conv3_pkg::out_rsp_t             out_rsp_o
);
  import conv3_pkg::*;

  typedef enum logic [1:0] {
    PH_MAIN = 2'b01,
    PH_TAIL = 2'b10
  } phase_e;

  typedef struct packed {
    logic [COL_W-1:0] col;
    pix_t             pix;
    logic             row_end;
    logic             drain;
    logic             r_ge1;
    logic             r_ge2;
  } s1_t;

  // Line RAM entry: previous row in the upper byte, the row before in the lower
  localparam int unsigned ENT_W = 2 * PIX_W;

  kern_t              kern_q;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [DIM_W-1:0]   row_q, row_d;
  logic               in_acc;
  logic               row_end_now, drain_now;
  pix_t               pix_now;
  logic               s1_valid_q;
  phase_e             s1_phase_q;
  s1_t                s1_q;
  logic               need_a, need_b, job_valid, job_ready, s1_adv, s1_done, commit;
  logic [ENT_W-1:0]   line_mem [MAX_WIDTH];
  logic [ENT_W-1:0]   rd_q, ent, wr_ent;
  logic               fwd_valid_q;
  logic [COL_W-1:0]   fwd_addr_q;
  logic [ENT_W-1:0]   fwd_data_q;
  pix_t               top_px, mid_px;
  win_t               win_q, win_base, win_main, win_tail;
  job_t               job;

  function automatic win_t shift_col(win_t w, pix_t t, pix_t m, pix_t b);
    win_t s;
    for (int r = 0; r < 3; r++) begin
      s[r][0] = w[r][1];
      s[r][1] = w[r][2];
    end
    s[0][2] = t;
    s[1][2] = m;
    s[2][2] = b;
    return s;
  endfunction

  // Configuration writes; sizes are stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0] <= '0;
      kern_q[1] <= KERN_MID_RESET;
      kern_q[2] <= '0;
      width_q   <= DIM_W'(MAX_WIDTH);
      height_q  <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KERN_TOP: kern_q[0] <= cfg_wdata_i;
        CFG_KERN_MID: kern_q[1] <= cfg_wdata_i;
        CFG_KERN_BOT: kern_q[2] <= cfg_wdata_i;
        CFG_WIDTH:    width_q   <= clamp_dim(cfg_wdata_i[DIM_W-1:0], DIM_W'(MAX_WIDTH));
        CFG_HEIGHT:   height_q  <= clamp_dim(cfg_wdata_i[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // Position of the incoming request
  assign in_acc      = in_valid_i && in_ready_o;
  assign row_end_now = DIM_W'(col_q) >= (width_q - DIM_W'(1));
  assign drain_now   = row_q >= height_q;
  assign pix_now     = (drain_now || in_req_i.func) ? '0 : in_req_i.pixel_in;

  always_comb begin
    if (row_end_now) begin
      col_d = '0;
      row_d = drain_now ? '0 : row_q + DIM_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Window stage control: main pass, then at a row end below row 0 a right-padding tail pass
  assign need_a    = s1_q.r_ge1 && (s1_q.col != '0);
  assign need_b    = s1_q.row_end && s1_q.r_ge1;
  assign job_valid = s1_valid_q && ((s1_phase_q == PH_MAIN) ? need_a : 1'b1);
  assign s1_adv    = s1_valid_q && (!job_valid || job_ready);
  assign s1_done   = s1_adv && ((s1_phase_q == PH_TAIL) || !need_b);
  assign commit    = s1_adv && (s1_phase_q == PH_MAIN);
  assign in_ready_o = !s1_valid_q || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= PH_MAIN;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
      s1_phase_q <= PH_MAIN;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= PH_MAIN;
    end else if (commit) begin
      s1_phase_q <= PH_TAIL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.col     <= col_q;
      s1_q.pix     <= pix_now;
      s1_q.row_end <= row_end_now;
      s1_q.drain   <= drain_now;
      s1_q.r_ge1   <= row_q >= DIM_W'(1);
      s1_q.r_ge2   <= row_q >= DIM_W'(2);
    end
  end

  // Line RAM: read on accept, write back the shifted column on commit
  assign ent    = (fwd_valid_q && (fwd_addr_q == s1_q.col)) ? fwd_data_q : rd_q;
  assign wr_ent = {s1_q.pix, ent[ENT_W-1:PIX_W]};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[col_q];
    end
    if (commit) begin
      line_mem[s1_q.col] <= wr_ent;
      fwd_addr_q         <= s1_q.col;
      fwd_data_q         <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (commit) begin
      fwd_valid_q <= 1'b1;
    end
  end

  // Build the window; rows above the image and columns left of it read as zero
  assign top_px   = s1_q.r_ge2 ? ent[PIX_W-1:0] : '0;
  assign mid_px   = s1_q.r_ge1 ? ent[ENT_W-1:PIX_W] : '0;
  assign win_base = (s1_q.col == '0) ? '0 : win_q;
  assign win_main = shift_col(win_base, top_px, mid_px, s1_q.pix);
  assign win_tail = shift_col(win_q, '0, '0, '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (commit) begin
      win_q <= win_main;
    end
  end

  always_comb begin
    unique case (s1_phase_q)
      PH_MAIN: begin
        job.win        = win_main;
        job.run_last   = !need_b;
        job.frame_last = 1'b0;
      end
      PH_TAIL: begin
        job.win        = win_tail;
        job.run_last   = 1'b1;
        job.frame_last = s1_q.drain;
      end
      default: begin
        job.win        = win_main;
        job.run_last   = 1'b0;
        job.frame_last = 1'b0;
      end
    endcase
  end

  conv3_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (kern_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef NO_ASSERTIONS
  // The tail pass exists only for a row end below the first row
  a_tail_needs_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_phase_q == PH_TAIL) |-> s1_q.row_end && s1_q.r_ge1)
    else $error("tail pass without row end");

  // No new request while the tail result is still blocked
  a_tail_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_phase_q == PH_TAIL) && !job_ready |-> !in_ready_o)
    else $error("request taken during blocked tail pass");

  // A row end returns the column counter to zero
  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && row_end_now |=> col_q == '0)
    else $error("column counter did not wrap at row end");
`endif

endmodule

>>> rtl/conv3_filter.sv
// Multiply, sum and clamp pipeline for one 3x3 window per request.
module conv3_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  conv3_pkg::kern_t  kern_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  conv3_pkg::job_t   job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output conv3_pkg::out_rsp_t out_rsp_o
);
  import conv3_pkg::*;

  typedef struct packed {
    logic run_last;
    logic frame_last;
  } tag_t;

  logic                     p_valid_q, q_valid_q, out_valid_q;
  logic                     p_adv, q_adv, out_adv;
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [ROW_W-1:0]  row_d [3];
  logic signed [ROW_W-1:0]  row_q [3];
  logic signed [SUM_W-1:0]  sum_d;
  tag_t                     p_tag_q, q_tag_q;
  pix_t                     pix_d;
  out_rsp_t                 out_q;

  // Stall chain: each stage moves when the next one has room
  assign out_adv     = out_ready_i || !out_valid_q;
  assign q_adv       = !q_valid_q || out_adv;
  assign p_adv       = !p_valid_q || q_adv;
  assign job_ready_o = p_adv;

  // Nine tap products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PROD_W'($signed(kern_i[r][c*COEF_BITS +: COEF_BITS]))
                     * PROD_W'($signed({1'b0, job_i.win[r][c]}));
      end
    end
  end

  // Per-row partial sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_d[r] = ROW_W'(prod_q[r][0]) + ROW_W'(prod_q[r][1]) + ROW_W'(prod_q[r][2]);
    end
  end

  // Total, floor to integer and saturate to 0..255
  always_comb begin
    sum_d = SUM_W'(row_q[0]) + SUM_W'(row_q[1]) + SUM_W'(row_q[2]);
    if (sum_d[SUM_W-1]) begin
      pix_d = '0;
    end else if (sum_d[SUM_W-2:FRAC_BITS+PIX_W] != '0) begin
      pix_d = '1;
    end else begin
      pix_d = sum_d[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      q_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p_adv) begin
        p_valid_q <= job_valid_i;
      end
      if (q_adv) begin
        q_valid_q <= p_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= q_valid_q;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (p_adv && job_valid_i) begin
      prod_q            <= prod_d;
      p_tag_q.run_last   <= job_i.run_last;
      p_tag_q.frame_last <= job_i.frame_last;
    end
    if (q_adv && p_valid_q) begin
      row_q   <= row_d;
      q_tag_q <= p_tag_q;
    end
    if (out_adv && q_valid_q) begin
      out_q.pixel_out  <= pix_d;
      out_q.run_last   <= q_tag_q.run_last;
      out_q.frame_last <= q_tag_q.frame_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  // The bottom-right pixel always closes its request
  a_frame_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_last |-> out_q.run_last)
    else $error("frame_last without run_last");

  // A stalled product stage keeps its entry
  a_prod_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !q_adv |=> p_valid_q)
    else $error("product stage dropped an entry");

  // A stalled result keeps its payload
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");
`endif

endmodule

>>> verif/conv3x3_zero_pad_clamp_tb.sv
// Self-checking testbench for the streaming 3x3 convolution filter.
`timescale 1ns / 100ps

module conv3x3_zero_pad_clamp_tb;
  import conv3_pkg::*;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Kernel row flavors for random configuration
  localparam int KMODE_RAW   = 0;
  localparam int KMODE_SOFT  = 1;
  localparam int KMODE_EDGE  = 2;

  localparam int RANDOM_ITEMS   = 500;
  localparam int EXTREME_ITEMS  = 24;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [KREG_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_req_t              in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_rsp_t             out_rsp_o;

  // Stimulus and expectation stores
  in_req_t  pixel_queue [$];
  out_rsp_t expected_px [$];

  // Shadow of the filter state
  logic [KREG_W-1:0] kern_rows [3];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  pix_t              line_a [MAX_WIDTH];
  pix_t              line_b [MAX_WIDTH];
  win_t              pred_win;
  int unsigned       col_cnt;
  int unsigned       row_cnt;

  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  int send_gap       = 0;
  int recv_stall     = 0;
  int idle_cycles    = 0;

  int fail_count      = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int frames_seen     = 0;
  int settings_run    = 0;
  int items_queued    = 0;

  out_rsp_t want_px;

  conv3x3_zero_pad_clamp dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Map zero to one and saturate at the maximum size
  function automatic int unsigned dim_limit(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == '0) begin
      return 1;
    end
    return (v > maxv) ? maxv : int'(v);
  endfunction

  // Slide the window left and load a new right column
  function automatic void shift_window(pix_t top, pix_t mid, pix_t bot);
    for (int r = 0; r < 3; r++) begin
      pred_win[r][0] = pred_win[r][1];
      pred_win[r][1] = pred_win[r][2];
    end
    pred_win[0][2] = top;
    pred_win[1][2] = mid;
    pred_win[2][2] = bot;
  endfunction

  // Correlate the window with the signed Q8.8 taps, floor and clamp
  function automatic pix_t window_value();
    longint acc;
    logic signed [COEF_BITS-1:0] tap;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap = kern_rows[r][COEF_BITS*c +: COEF_BITS];
        acc += longint'(tap) * longint'(pred_win[r][c]);
      end
    end
    if (acc < 0) begin
      return '0;
    end
    acc = acc >>> FRAC_BITS;
    return (acc > 255) ? pix_t'(255) : pix_t'(acc);
  endfunction

  // Advance the shadow state by one accepted request and queue its results
  function automatic void conv_predict(in_req_t req);
    int unsigned w, h, ci;
    bit          drain, row_end;
    pix_t        p, top, mid;
    out_rsp_t    rsp [2];
    int          n;
    w       = dim_limit(width_reg, MAX_WIDTH);
    h       = dim_limit(height_reg, MAX_HEIGHT);
    drain   = row_cnt >= h;
    row_end = col_cnt >= w - 1;
    p       = (drain || req.func == FUNC_DRAIN) ? pix_t'(0) : req.pixel_in;
    ci      = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
    top     = (row_cnt >= 2) ? line_b[ci] : pix_t'(0);
    mid     = (row_cnt >= 1) ? line_a[ci] : pix_t'(0);
    n       = 0;
    if (col_cnt == 0) begin
      pred_win = '0;
    end
    shift_window(top, mid, p);
    line_b[ci] = line_a[ci];
    line_a[ci] = p;
    if (row_cnt >= 1 && col_cnt >= 1) begin
      rsp[n] = '{pixel_out: window_value(), run_last: 1'b0, frame_last: 1'b0};
      n++;
    end
    // Flush the right padding column at the end of a row
    if (row_end) begin
      shift_window('0, '0, '0);
      if (row_cnt >= 1) begin
        rsp[n] = '{pixel_out: window_value(), run_last: 1'b0, frame_last: drain};
        n++;
      end
      col_cnt = 0;
      row_cnt = drain ? 0 : (row_cnt + 1) % (1 << DIM_W);
    end else begin
      col_cnt++;
    end
    if (n > 0) begin
      rsp[n-1].run_last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_px = {expected_px, rsp[i]};
    end
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [KREG_W-1:0] rand_kernel_row(int mode);
    logic [63:0]        wide;
    logic [KREG_W-1:0]  row;
    logic [15:0]        tap;
    wide = {$urandom(), $urandom()};
    row  = wide[KREG_W-1:0];
    if (mode != KMODE_RAW) begin
      for (int c = 0; c < 3; c++) begin
        if (mode == KMODE_SOFT) begin
          tap = 16'($urandom_range(0, 160)) - 16'd48;
        end else begin
          case ($urandom_range(0, 4))
            0:       tap = 16'h7FFF;
            1:       tap = 16'h8000;
            2:       tap = 16'h0000;
            3:       tap = 16'h0100;
            default: tap = 16'hFFFF;
          endcase
        end
        row[COEF_BITS*c +: COEF_BITS] = tap;
      end
    end
    return row;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // Write one register and mirror it in the shadow state
  task automatic write_reg(input cfg_reg_e idx, input logic [KREG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_KERN_TOP: kern_rows[0] = data;
      CFG_KERN_MID: kern_rows[1] = data;
      CFG_KERN_BOT: kern_rows[2] = data;
      CFG_WIDTH:    width_reg    = data[DIM_W-1:0];
      CFG_HEIGHT:   height_reg   = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || expected_px.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_item(input logic func, input pix_t pix);
    in_req_t req;
    req.func     = func;
    req.pixel_in = pix;
    pixel_queue  = {pixel_queue, req};
    items_queued++;
  endtask

  // Queue the rest of a frame from a given position, drain row included
  task automatic queue_frame(input int unsigned row0, input int unsigned col0,
                             input int noise_pct, input int hold_at);
    int unsigned w, h, r, c;
    int          n;
    bit          done;
    logic        func;
    w    = dim_limit(width_reg, MAX_WIDTH);
    h    = dim_limit(height_reg, MAX_HEIGHT);
    r    = row0;
    c    = col0;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      func = (r >= h) ? FUNC_DRAIN : FUNC_PIXEL;
      if ($urandom_range(1, 100) <= noise_pct) begin
        func = ~func;
      end
      push_item(func, rand_pixel());
      n++;
      if (n == hold_at) begin
        wait_drained();
      end
      if (c >= w - 1) begin
        done = (r >= h);
        r++;
        c = 0;
      end else begin
        c++;
      end
    end
  endtask

  // Driver: present queued requests with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        conv_predict(in_req_i);
        pixels_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_req_i   <= pixel_queue.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= sender_quiet ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random stalls and compare against the shadow
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (out_rsp_o.frame_last === 1'b1) begin
          frames_seen++;
        end
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("unrequested result, pixel_out %0d", out_rsp_o.pixel_out));
        end else begin
          want_px = expected_px.pop_front();
          if (out_rsp_o.pixel_out !== want_px.pixel_out) begin
            report_mismatch($sformatf("pixel_out got %0d expected %0d",
                                      out_rsp_o.pixel_out, want_px.pixel_out));
          end
          if (out_rsp_o.run_last !== want_px.run_last) begin
            report_mismatch($sformatf("run_last got %b expected %b",
                                      out_rsp_o.run_last, want_px.run_last));
          end
          if (out_rsp_o.frame_last !== want_px.frame_last) begin
            report_mismatch($sformatf("frame_last got %b expected %b",
                                      out_rsp_o.frame_last, want_px.frame_last));
          end
        end
        recv_stall = receiver_quiet ? 0 : $urandom_range(0, 6);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready_i <= (recv_stall == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", idle_cycles);
      $display("conv3x3_zero_pad_clamp verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_reg_e          kern_regs [3];
    logic [DIM_W-1:0]  big_w [4];
    logic [DIM_W-1:0]  big_h [4];
    int                start_items;
    int                mode;
    int                hold_at;
    int                noise;

    kern_regs = '{CFG_KERN_TOP, CFG_KERN_MID, CFG_KERN_BOT};
    big_w     = '{11'd1024, 11'd0,    11'd2047, 11'd1};
    big_h     = '{11'd0,    11'd1024, 11'd1,    11'd2047};

    // Load the shadow with the reset state
    kern_rows[0] = '0;
    kern_rows[1] = KERN_MID_RESET;
    kern_rows[2] = '0;
    width_reg    = DIM_W'(MAX_WIDTH);
    height_reg   = DIM_W'(MAX_HEIGHT);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    pred_win = '0;
    col_cnt  = 0;
    row_cnt  = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pass-through with the reset kernel
    write_reg(CFG_WIDTH, 48'd3);
    write_reg(CFG_HEIGHT, 48'd2);
    settings_run++;
    queue_frame(0, 0, 0, 0);

    // Largest positive taps; drain tick inside the image, pixel in the drain row
    wait_drained();
    foreach (kern_regs[i]) write_reg(kern_regs[i], 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_WIDTH, 48'd2);
    write_reg(CFG_HEIGHT, 48'd2);
    settings_run++;
    push_item(FUNC_PIXEL, 8'hFF);
    push_item(FUNC_DRAIN, 8'hAB);
    push_item(FUNC_PIXEL, 8'h00);
    push_item(FUNC_PIXEL, 8'hFF);
    push_item(FUNC_PIXEL, 8'h5A);
    push_item(FUNC_DRAIN, 8'hFF);

    // Most negative taps on a one-row image
    wait_drained();
    foreach (kern_regs[i]) write_reg(kern_regs[i], 48'h8000_8000_8000);
    write_reg(CFG_HEIGHT, 48'd1);
    settings_run++;
    push_item(FUNC_PIXEL, 8'hFF);
    push_item(FUNC_PIXEL, 8'h01);
    push_item(FUNC_DRAIN, 8'h00);
    push_item(FUNC_PIXEL, 8'h77);

    // Single-pixel frame with mixed extreme taps
    wait_drained();
    foreach (kern_regs[i]) write_reg(kern_regs[i], rand_kernel_row(KMODE_EDGE));
    write_reg(CFG_WIDTH, 48'd1);
    settings_run++;
    queue_frame(0, 0, 0, 0);

    // Shrink width and height in the middle of a frame
    wait_drained();
    foreach (kern_regs[i]) write_reg(kern_regs[i], 48'h001C_001C_001C);
    write_reg(CFG_WIDTH, 48'd4);
    write_reg(CFG_HEIGHT, 48'd3);
    settings_run++;
    repeat (6) push_item(FUNC_PIXEL, rand_pixel());
    wait_drained();
    write_reg(CFG_WIDTH, 48'd2);
    write_reg(CFG_HEIGHT, 48'd2);
    settings_run++;
    queue_frame(row_cnt, col_cnt, 0, 0);

    // Size extremes, zero and out-of-range sizes; cut the frame short by a shrink
    for (int i = 0; i < 4; i++) begin
      wait_drained();
      foreach (kern_regs[k]) write_reg(kern_regs[k], rand_kernel_row(KMODE_SOFT));
      write_reg(CFG_WIDTH, KREG_W'(big_w[i]));
      write_reg(CFG_HEIGHT, KREG_W'(big_h[i]));
      settings_run++;
      sender_quiet   <= (i % 2 == 0);
      receiver_quiet <= (i == 1);
      repeat (EXTREME_ITEMS) push_item(FUNC_PIXEL, rand_pixel());
      wait_drained();
      if (dim_limit(width_reg, MAX_WIDTH) > EXTREME_ITEMS) begin
        write_reg(CFG_WIDTH, KREG_W'(EXTREME_ITEMS));
      end
      if (dim_limit(height_reg, MAX_HEIGHT) > EXTREME_ITEMS) begin
        write_reg(CFG_HEIGHT, KREG_W'(EXTREME_ITEMS));
      end
      queue_frame(row_cnt, col_cnt, 3, 0);
    end

    // Random frames under random settings
    wait_drained();
    write_reg(CFG_WIDTH, 48'd5);
    write_reg(CFG_HEIGHT, 48'd3);
    start_items = items_queued;
    while (items_queued - start_items < RANDOM_ITEMS) begin
      wait_drained();
      foreach (kern_regs[k]) begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 5))
            0:       mode = KMODE_RAW;
            5:       mode = KMODE_EDGE;
            default: mode = KMODE_SOFT;
          endcase
          write_reg(kern_regs[k], rand_kernel_row(mode));
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 5) == 0) begin
          write_reg(CFG_WIDTH, KREG_W'($urandom_range(13, 40)));
          write_reg(CFG_HEIGHT, KREG_W'($urandom_range(1, 3)));
        end else begin
          write_reg(CFG_WIDTH, KREG_W'($urandom_range(1, 12)));
        end
      end
      if ($urandom_range(0, 1) == 1 && width_reg <= 12) begin
        write_reg(CFG_HEIGHT, KREG_W'($urandom_range(1, 6)));
      end
      settings_run++;
      sender_quiet   <= ($urandom_range(0, 3) == 0);
      receiver_quiet <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        noise   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : 0;
        hold_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
        queue_frame(0, 0, noise, hold_at);
      end
    end

    wait_drained();
    $display("Covered %0d requests and %0d checked results over %0d filter settings,",
             pixels_sent, results_checked, settings_run);
    $display("including %0d completed frames, size extremes and a mid-frame resize.",
             frames_seen);
    if (fail_count == 0) begin
      $display("conv3x3_zero_pad_clamp verification clean");
    end else begin
      $display("conv3x3_zero_pad_clamp verification failed");
    end
    $finish;
  end

endmodule

>>> conv3x3_zero_pad_clamp.f
rtl/conv3_pkg.sv
rtl/conv3_filter.sv
rtl/conv3x3_zero_pad_clamp.sv
verif/conv3x3_zero_pad_clamp_tb.sv
